// ===== hdl/pcbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types and constants of the prefix code bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

    // Longest code the table accepts; longer lengths saturate to LenCap
    localparam int MaxCodeBits = 32;
    localparam int CodeW       = 32;
    localparam int LenW        = 6;
    localparam int SymW        = 8;
    localparam int TblDepth    = 256;
    localparam int LenCap      = (MaxCodeBits < CodeW) ? MaxCodeBits : CodeW;

    // Accumulator: up to seven pending bits plus one full code
    localparam int PendW = 7;
    localparam int AccW  = PendW + LenCap;
    localparam int ExtW  = AccW + 8;
    localparam int CntW  = $clog2(AccW + 1);

    // Item kinds
    localparam logic KindLoad   = 1'b0;
    localparam logic KindEncode = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [SymW-1:0]  symbol;
        logic [CodeW-1:0] code_bits;
        logic [LenW-1:0]  code_length;
        logic             stream_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] packed_byte;
        logic       run_last;
        logic       stream_end;
    } out_item_t;

    typedef struct packed {
        logic [CodeW-1:0] code;
        logic [LenW-1:0]  len;
    } tbl_entry_t;

    typedef struct packed {
        logic            en;
        logic [SymW-1:0] addr;
        tbl_entry_t      entry;
    } tbl_wr_t;

    typedef struct packed {
        logic            left;
        logic [CntW-1:0] amt;
        logic [ExtW-1:0] data;
    } shift_req_t;

endpackage

// ===== hdl/pcbp_code_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbp_code_table
// Code table memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pcbp_code_table (
    input  logic                      clk,
    input  pcbp_pkg::tbl_wr_t         wr,
    input  logic                      rd_en,
    input  logic [pcbp_pkg::SymW-1:0] rd_addr,
    output pcbp_pkg::tbl_entry_t      rd_data
);
    import pcbp_pkg::*;

    tbl_entry_t mem [TblDepth];
    tbl_entry_t rd_data_reg;

    // Write one entry per load request
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.entry;
        end
    end

    // Register the looked-up entry
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/pcbp_shifter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbp_shifter
// Shared barrel shifter: left shift to merge a code, right shift to extract
// a byte from the accumulator.
// ----------------------------------------------------------------------------
module pcbp_shifter (
    input  pcbp_pkg::shift_req_t        req,
    output logic [pcbp_pkg::ExtW-1:0]   result
);
    import pcbp_pkg::*;

    // Shift in the requested direction, zero fill
    always_comb
    begin
        if (req.left)
        begin
            result = req.data << req.amt;
        end
        else
        begin
            result = req.data >> req.amt;
        end
    end

endmodule

// ===== hdl/prefix_code_bit_packer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prefix_code_bit_packer
// Prefix code (Huffman) bit packer with a 256-entry loadable code table.
// ----------------------------------------------------------------------------
// A load request writes one table entry in the cycle it is accepted and the
// block is ready again in the next cycle. An encode request first reads the
// table through its registered port, then merges the code behind the pending
// bits through the shared shifter, then emits 0 to 5 bytes, one byte per
// cycle out of the same shifter, each only when the output register is free.
// No further request is taken until an encode request is finished; the last
// byte may still wait in the output register while the next request is
// accepted. Encoding a symbol whose entry was never loaded gives undefined
// bytes. The table needs no clearing after reset.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  pcbp_pkg::in_item_t  req,
    output logic                res_valid,
    input  logic                res_ready,
    output pcbp_pkg::out_item_t res
);
    import pcbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MERGE,
        ST_EMIT
    } state_t;

    state_t                 state_reg, state_next;
    logic [AccW-1:0]        acc_reg, acc_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   slast_reg, slast_next;
    logic [PendW-1:0]       pend_bits_reg, pend_bits_next;
    logic [2:0]             pend_cnt_reg, pend_cnt_next;
    logic                   res_valid_reg, res_valid_next;
    out_item_t              res_reg, res_next;

    logic                   accept;
    tbl_wr_t                tbl_wr;
    tbl_entry_t             tbl_rd;
    logic [LenW-1:0]        len_sat;
    shift_req_t             sh_req;
    logic [ExtW-1:0]        sh_out;
    logic [AccW-1:0]        acc_merge;
    logic [CntW-1:0]        cnt_merge;
    logic [CntW-1:0]        cnt_after;
    logic                   more;
    logic                   out_free;

    // Keep only the low cnt bits of the accumulator as pending bits
    function automatic logic [PendW-1:0] pend_mask(input logic [PendW-1:0] bits,
                                                   input logic [2:0] cnt);
        pend_mask = bits & ~({PendW{1'b1}} << cnt);
    endfunction

    assign req_ready = (state_reg == ST_IDLE);
    assign accept    = req_valid && req_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || res_ready;

    // Saturate the length and drop code bits above it
    assign len_sat = (req.code_length > LenW'(LenCap)) ? LenW'(LenCap) : req.code_length;

    always_comb
    begin
        tbl_wr.en         = accept && (req.kind == KindLoad);
        tbl_wr.addr       = req.symbol;
        tbl_wr.entry.len  = len_sat;
        tbl_wr.entry.code = req.code_bits & ~({CodeW{1'b1}} << len_sat);
    end

    pcbp_code_table u_table (
        .clk     (clk),
        .wr      (tbl_wr),
        .rd_en   (accept && (req.kind == KindEncode)),
        .rd_addr (req.symbol),
        .rd_data (tbl_rd)
    );

    // Drive the shared shifter: merge in ST_MERGE, byte extract otherwise
    always_comb
    begin
        if (state_reg == ST_MERGE)
        begin
            sh_req.left = 1'b1;
            sh_req.amt  = CntW'(tbl_rd.len);
            sh_req.data = ExtW'(pend_bits_reg);
        end
        else
        begin
            sh_req.left = 1'b0;
            sh_req.amt  = cnt_reg;
            sh_req.data = {acc_reg, 8'h00};
        end
    end

    pcbp_shifter u_shift (
        .req    (sh_req),
        .result (sh_out)
    );

    assign acc_merge = sh_out[AccW-1:0] | AccW'(tbl_rd.code);
    assign cnt_merge = CntW'(pend_cnt_reg) + CntW'(tbl_rd.len);
    assign cnt_after = (cnt_reg >= CntW'(8)) ? cnt_reg - CntW'(8) : '0;
    assign more      = (cnt_after >= CntW'(8)) || (slast_reg && (cnt_after != '0));

    // Sequencer next state
    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        slast_next     = slast_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        res_valid_next = res_valid_reg && !res_ready;
        res_next       = res_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.kind == KindEncode))
                begin
                    slast_next = req.stream_last;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                acc_next = acc_merge;
                cnt_next = cnt_merge;
                if ((cnt_merge >= CntW'(8)) || (slast_reg && (cnt_merge != '0)))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    pend_bits_next = pend_mask(acc_merge[PendW-1:0], cnt_merge[2:0]);
                    pend_cnt_next  = cnt_merge[2:0];
                    state_next     = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next      = 1'b1;
                    res_next.packed_byte = sh_out[7:0];
                    res_next.run_last   = !more;
                    res_next.stream_end = !more && slast_reg;
                    cnt_next            = cnt_after;
                    if (!more)
                    begin
                        pend_bits_next = pend_mask(acc_reg[PendW-1:0], cnt_after[2:0]);
                        pend_cnt_next  = cnt_after[2:0];
                        state_next     = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            slast_reg     <= 1'b0;
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            res_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            slast_reg     <= slast_next;
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            res_valid_reg <= res_valid_next;
            res_reg       <= res_next;
        end
    end

endmodule

// ===== hdl/pcbp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcbp_checker
// Port-level checks of the bit packer, bound to the top level.
// ----------------------------------------------------------------------------
module pcbp_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input pcbp_pkg::in_item_t  req,
    input logic                res_valid,
    input logic                res_ready,
    input pcbp_pkg::out_item_t res
);
    import pcbp_pkg::*;

    // A stalled request holds
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_ready |=> req_valid && $stable(req))
        else $error("request changed while stalled");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    // End of stream always closes a run
    a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!res.stream_end || res.run_last))
        else $error("stream end without run end");

    // An encode request keeps the block busy for the lookup
    a_encode_busy: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req.kind == KindEncode) |=> !req_ready)
        else $error("ready right after encode request");

endmodule

bind prefix_code_bit_packer pcbp_checker u_pcbp_checker (.*);
